/* hw/rtl/dqfr_pkg.sv */
// Shared types and constants for the deque with find-and-replace.
`default_nettype none

package dqfr_pkg;

  // Default sizing, handed down through the top-level parameters.
  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed port widths.
  localparam int OPCODE_W = 3;
  localparam int IN_W     = 32;
  localparam int STATUS_W = 2;
  localparam int OUT_CNT_W = 5;

  // Operation codes carried by an input beat.
  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_POP_BACK   = 3'd1,
    OP_PUSH_FRONT = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_REPLACE    = 3'd4
  } op_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE    = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_NOMATCH = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_t;

  // Row-wide shift commands broadcast to every cell.
  typedef struct packed {
    logic push_front;
    logic pop_front;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/dqfr_cell.sv */
// One storage cell of the deque row: holds an entry and passes the search token on.
`default_nettype none

module dqfr_cell #(
  parameter int DATA_WIDTH = dqfr_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dqfr_pkg::cell_ctrl_t  ctl,
  input  logic                  wr_back,
  input  logic                  valid,
  input  logic                  tok_in,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  input  logic [DATA_WIDTH-1:0] push_data,
  input  logic [DATA_WIDTH-1:0] key,
  input  logic [DATA_WIDTH-1:0] repl_data,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic                  tok_out,
  output logic                  hit
);
  import dqfr_pkg::*;

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  logic                  tok_r;

  // The cell matches when it holds the token and a live entry equal to the key.
  assign hit     = tok_r & valid & (data_r == key);
  assign tok_out = tok_r & valid & ~hit;
  assign data_o  = data_r;

  // Entry update: shift towards the back, shift towards the front, load or replace.
  always_comb begin
    data_nxt = data_r;
    if (ctl.push_front) begin
      data_nxt = left_data;
    end else if (ctl.pop_front) begin
      data_nxt = right_data;
    end else if (wr_back) begin
      data_nxt = push_data;
    end else if (hit) begin
      data_nxt = repl_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  // Search token register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_in;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/deque_with_find_replace_unit.sv */
// Top level of the deque with find-and-replace, built as a row of shifting cells.
//
// Usage: present in_opcode, in_value and in_new_value with start high; the beat is
// taken at a rising edge where start is high and busy is low. Each beat yields one
// result beat: out_valid is high for exactly one cycle with out_status and
// out_entry_count, and the receiver must take it then, since it cannot stall.
// Entries sit in cells ordered from the front (cell 0) to the back. Push and pop at
// the front shift the whole row by one cell; push and pop at the back touch only
// the cell at the fill level. These take one cycle each: the result appears in the
// cycle after the beat and the next beat may be taken in that same cycle.
// Replace walks a token from cell 0 towards the back, one cell a cycle, and busy is
// high meanwhile; it finishes on the first match or at the fill level, so its
// result arrives once the token walk stops, and no new beat is taken until then.
// Reset (synchronous, rst_n low) empties the deque and cancels any search; the
// cell contents are not cleared, as cells beyond the fill level are never read.
`default_nettype none

module deque_with_find_replace_unit #(
  parameter int CAPACITY   = dqfr_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = dqfr_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [dqfr_pkg::OPCODE_W-1:0]     in_opcode,
  input  logic signed [dqfr_pkg::IN_W-1:0]  in_value,
  input  logic signed [dqfr_pkg::IN_W-1:0]  in_new_value,
  output logic                              out_valid,
  output logic [dqfr_pkg::STATUS_W-1:0]     out_status,
  output logic [dqfr_pkg::OUT_CNT_W-1:0]    out_entry_count
);
  import dqfr_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      pos_r, pos_nxt;
  logic [DATA_WIDTH-1:0] key_r, key_nxt;
  logic [DATA_WIDTH-1:0] repl_r, repl_nxt;
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;

  cell_ctrl_t            ctl;
  logic                  wr_back_en;
  logic                  scan_start;
  logic                  full;
  logic                  empty;
  logic [DATA_WIDTH-1:0] push_data;

  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic                  tok_vec   [CAPACITY];
  logic                  hit_vec   [CAPACITY];

  assign full      = (count_r == CNT_W'(CAPACITY));
  assign empty     = (count_r == '0);
  assign push_data = DATA_WIDTH'(in_value);
  assign busy      = (state_r == S_SCAN);

  // Row of cells; each takes its neighbours' entries for the front shifts.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d;
    logic [DATA_WIDTH-1:0] right_d;
    logic                  tok_i;

    if (i == 0) begin : g_first
      assign left_d = push_data;
      assign tok_i  = scan_start;
    end else begin : g_mid
      assign left_d = cell_data[i-1];
      assign tok_i  = tok_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_d = cell_data[i];
    end else begin : g_inner
      assign right_d = cell_data[i+1];
    end

    dqfr_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .wr_back    (wr_back_en & (count_r == CNT_W'(i))),
      .valid      (CNT_W'(i) < count_r),
      .tok_in     (tok_i),
      .left_data  (left_d),
      .right_data (right_d),
      .push_data  (push_data),
      .key        (key_r),
      .repl_data  (repl_r),
      .data_o     (cell_data[i]),
      .tok_out    (tok_vec[i]),
      .hit        (hit_vec[i])
    );
  end

  // Next state, row commands and result for each beat.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    key_nxt        = key_r;
    repl_nxt       = repl_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    ctl            = '0;
    wr_back_en     = 1'b0;
    scan_start     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_DONE;
          case (op_t'(in_opcode))
            OP_PUSH_BACK: begin
              if (full) begin
                out_status_nxt = STAT_FULL;
              end else begin
                wr_back_en = 1'b1;
                count_nxt  = count_r + 1'b1;
              end
            end
            OP_POP_BACK: begin
              if (empty) begin
                out_status_nxt = STAT_EMPTY;
              end else begin
                count_nxt = count_r - 1'b1;
              end
            end
            OP_PUSH_FRONT: begin
              if (full) begin
                out_status_nxt = STAT_FULL;
              end else begin
                ctl.push_front = 1'b1;
                count_nxt      = count_r + 1'b1;
              end
            end
            OP_POP_FRONT: begin
              if (empty) begin
                out_status_nxt = STAT_EMPTY;
              end else begin
                ctl.pop_front = 1'b1;
                count_nxt     = count_r - 1'b1;
              end
            end
            OP_REPLACE: begin
              out_valid_nxt = 1'b0;
              scan_start    = 1'b1;
              pos_nxt       = '0;
              key_nxt       = DATA_WIDTH'(in_value);
              repl_nxt      = DATA_WIDTH'(in_new_value);
              state_nxt     = S_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (pos_r == count_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_NOMATCH;
          state_nxt      = S_IDLE;
        end else if (hit_vec[pos_r[IDX_W-1:0]]) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_DONE;
          state_nxt      = S_IDLE;
        end else begin
          pos_nxt = pos_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Search operands and result status.
  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    repl_r       <= repl_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_count = OUT_CNT_W'(count_r);

endmodule

`default_nettype wire

/* sim/tb.sv */
// Self-checking testbench for the deque with find-and-replace unit.
`default_nettype none

module tb;
  import dqfr_pkg::*;

  localparam int DEPTH       = CAPACITY_DEF;
  localparam int DW          = DATA_WIDTH_DEF;
  localparam int RANDOM_OPS  = 2000;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 2 * DEPTH + 8;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [OPCODE_W-1:0]     in_opcode;
  logic signed [IN_W-1:0]  in_value;
  logic signed [IN_W-1:0]  in_new_value;
  logic                    out_valid;
  logic [STATUS_W-1:0]     out_status;
  logic [OUT_CNT_W-1:0]    out_entry_count;

  deque_with_find_replace_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_value        (in_value),
    .in_new_value    (in_new_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

  // Keeps a mirror of the deque contents, front first, and the results still due.
  class deque_scoreboard;
    logic [DW-1:0]        mirror[$];
    status_t              due_status[$];
    logic [OUT_CNT_W-1:0] due_count[$];
    int                   fails;

    function new();
      fails = 0;
    endfunction

    function void report(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      fails++;
    endfunction

    function int pending();
      return due_status.size();
    endfunction

    // Applies one accepted beat to the mirror and queues the result it must give.
    function void note_beat(logic [OPCODE_W-1:0] op, logic [DW-1:0] val,
                            logic [DW-1:0] nval);
      status_t st;
      bit      hit;
      st  = STAT_DONE;
      hit = 1'b0;
      case (op)
        OP_PUSH_BACK: begin
          if (mirror.size() >= DEPTH) st = STAT_FULL;
          else mirror.push_back(val);
        end
        OP_POP_BACK: begin
          if (mirror.size() == 0) st = STAT_EMPTY;
          else void'(mirror.pop_back());
        end
        OP_PUSH_FRONT: begin
          if (mirror.size() >= DEPTH) st = STAT_FULL;
          else mirror.push_front(val);
        end
        OP_POP_FRONT: begin
          if (mirror.size() == 0) st = STAT_EMPTY;
          else void'(mirror.pop_front());
        end
        OP_REPLACE: begin
          // Only the match nearest the front is rewritten.
          st = STAT_NOMATCH;
          for (int i = 0; i < mirror.size() && !hit; i++) begin
            if (mirror[i] == val) begin
              mirror[i] = nval;
              hit       = 1'b1;
              st        = STAT_DONE;
            end
          end
        end
        default: ;
      endcase
      due_status.push_back(st);
      due_count.push_back(OUT_CNT_W'(mirror.size()));
    endfunction

    // Compares one result beat with the oldest one still due.
    function void check_result(logic [STATUS_W-1:0] st, logic [OUT_CNT_W-1:0] cnt);
      status_t              want_st;
      logic [OUT_CNT_W-1:0] want_cnt;
      if (due_status.size() == 0) begin
        report($sformatf("unexpected result: status %0d count %0d", st, cnt));
        return;
      end
      want_st  = due_status.pop_front();
      want_cnt = due_count.pop_front();
      if (st !== want_st)
        report($sformatf("status %0d, expected %0d", st, want_st));
      if (cnt !== want_cnt)
        report($sformatf("entry count %0d, expected %0d", cnt, want_cnt));
    endfunction
  endclass

  deque_scoreboard sb = new();

  always #6 clk = ~clk;

  // Results cannot be held off, so every strobe is checked at the edge that ends it.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_status, out_entry_count);
  end

  // Ends the run if neither side moves a beat for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (start && !busy) || out_valid) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Presents one beat and holds it until the unit takes it.
  task automatic send_beat(input logic [OPCODE_W-1:0] op, input logic [DW-1:0] val,
                           input logic [DW-1:0] nval);
    start        <= 1'b1;
    in_opcode    <= op;
    in_value     <= val;
    in_new_value <= nval;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_beat(op, val, nval);
  endtask

  task automatic idle_for(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Holds the sender back until every outstanding result has come out.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Picks a data value, often one already held so that searches find matches.
  function automatic logic [DW-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35 && sb.mirror.size() != 0)
      return sb.mirror[$urandom_range(0, sb.mirror.size() - 1)];
    if (r < 55) return DW'($signed($urandom_range(0, 7)) - 3);
    if (r < 65) begin
      case ($urandom_range(0, 3))
        0: return {1'b1, {(DW-1){1'b0}}};
        1: return {1'b0, {(DW-1){1'b1}}};
        2: return '0;
        default: return '1;
      endcase
    end
    return DW'($urandom());
  endfunction

  // Chooses an operation weighted by the phase: filling, draining or mixed.
  function automatic logic [OPCODE_W-1:0] pick_op(input int phase);
    int r;
    r = $urandom_range(0, 99);
    if (r >= 95) return OPCODE_W'($urandom_range(5, 7));
    case (phase)
      0: begin
        if (r < 40) return OP_PUSH_BACK;
        if (r < 75) return OP_PUSH_FRONT;
        if (r < 90) return OP_REPLACE;
        return (r < 93) ? OP_POP_BACK : OP_POP_FRONT;
      end
      1: begin
        if (r < 35) return OP_POP_BACK;
        if (r < 70) return OP_POP_FRONT;
        if (r < 85) return OP_REPLACE;
        return (r < 90) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      end
      default: begin
        if (r < 30) return OP_REPLACE;
        if (r < 46) return OP_PUSH_BACK;
        if (r < 62) return OP_PUSH_FRONT;
        if (r < 78) return OP_POP_BACK;
        return OP_POP_FRONT;
      end
    endcase
  endfunction

  // Directed beats: empty pops, extreme values, duplicate matches and unused codes.
  task automatic run_directed();
    send_beat(OP_POP_BACK, 32'h0, 32'h0);
    send_beat(OP_POP_FRONT, 32'h0, 32'h0);
    send_beat(OP_REPLACE, 32'h0, 32'h1);
    send_beat(OP_PUSH_BACK, 32'h7fff_ffff, 32'h0);
    send_beat(OP_PUSH_FRONT, 32'h8000_0000, 32'hffff_ffff);
    idle_for(2);
    send_beat(OP_PUSH_BACK, 32'hffff_ffff, 32'h0);
    send_beat(OP_PUSH_FRONT, 32'h0000_0000, 32'h0);
    send_beat(OP_PUSH_BACK, 32'h7fff_ffff, 32'h0);
    send_beat(OP_REPLACE, 32'h7fff_ffff, 32'h5a5a_5a5a);
    send_beat(OP_REPLACE, 32'h7fff_ffff, 32'h8000_0000);
    send_beat(OP_REPLACE, 32'h1357_9bdf, 32'hffff_ffff);
    send_beat(OPCODE_W'(5), 32'hffff_ffff, 32'hffff_ffff);
    send_beat(OPCODE_W'(6), 32'h0, 32'h0);
    send_beat(OPCODE_W'(7), 32'h8000_0000, 32'h7fff_ffff);
    idle_for(1);
    send_beat(OP_POP_FRONT, 32'h0, 32'h0);
    send_beat(OP_POP_BACK, 32'h0, 32'h0);
    send_beat(OP_POP_BACK, 32'h0, 32'h0);
    send_beat(OP_POP_FRONT, 32'h0, 32'h0);
    send_beat(OP_POP_FRONT, 32'h0, 32'h0);
    send_beat(OP_POP_BACK, 32'h0, 32'h0);
    send_beat(OP_REPLACE, 32'hffff_ffff, 32'h0);
  endtask

  // Random beats in phases that mostly fill the deque, drain it, or mix.
  task automatic run_random();
    int            sent;
    int            seg_no;
    int            seg_len;
    int            phase;
    bit            no_gaps;
    logic [DW-1:0] nval;
    sent   = 0;
    seg_no = 0;
    while (sent < RANDOM_OPS) begin
      seg_len = $urandom_range(10, 40);
      phase   = $urandom_range(0, 2);
      for (int k = 0; k < seg_len && sent < RANDOM_OPS; k++) begin
        no_gaps = (sent >= 700 && sent < 1100);
        if (!no_gaps && $urandom_range(0, 99) < 18) idle_for($urandom_range(1, 3));
        nval = ($urandom_range(0, 9) < 3) ? pick_value() : DW'($urandom());
        send_beat(pick_op(phase), pick_value(), nval);
        sent++;
      end
      if (seg_no == 3 || $urandom_range(0, 5) == 0) settle();
      seg_no++;
    end
  endtask

  initial begin
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_opcode    <= OP_PUSH_BACK;
    in_value     <= '0;
    in_new_value <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();
    run_random();

    // Let the last results drain, then watch a little longer for strays.
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
